[hw/rtl/haplotype_distinct_labeler_defines.svh]
// Assertion macros for the distinct haplotype labeler.
// Used by modules that include this file; needs clk and arst_n in scope.
`ifndef HAPLOTYPE_DISTINCT_LABELER_DEFINES_SVH
`define HAPLOTYPE_DISTINCT_LABELER_DEFINES_SVH
`ifndef SYNTHESIS
`define HDL_ASSERT_NOW(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);
`define HDL_ASSERT_NEXT(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);
`else
`define HDL_ASSERT_NOW(lbl, a, b, msg)
`define HDL_ASSERT_NEXT(lbl, a, b, msg)
`endif
`endif

[hw/rtl/hdl_pkg.sv]
// Package for the distinct haplotype labeler: sizes, job type, word count helper.
// No dependencies.
`timescale 1ns / 1ps
package hdl_pkg;
	localparam int MAX_WORDS = 8;
	localparam int WORD_BITS = 30;
	localparam int ENTRIES   = 256;
	localparam int WIDX      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int LEN_W     = $clog2(MAX_WORDS + 1);
	localparam int ENT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int LABEL_W   = 9;
	localparam int CFG_W     = 4;
	localparam int QDEPTH    = 2;
	localparam int QPW       = 1;
	localparam int RAM_AW    = ENT_W + WIDX;
	localparam int RAM_DEPTH = ENTRIES << WIDX;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic                       clear;
		logic [LEN_W-1:0]           len;
		logic [MAX_WORDS-1:0][WORD_BITS-1:0] key;
	} job_t;

	function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] wiu);
		logic [LEN_W-1:0] r;
		if (wiu == '0) begin
			r = LEN_W'(1);
		end else if (32'(wiu) > MAX_WORDS) begin
			r = LEN_W'(MAX_WORDS);
		end else begin
			r = LEN_W'(wiu);
		end
		return r;
	endfunction
endpackage

[hw/rtl/hdl_ram.sv]
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module hdl_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hw/rtl/hdl_front.sv]
// Front part: collects haplotype words into keys and queues complete keys.
// Depends on hdl_pkg.
`timescale 1ns / 1ps
module hdl_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  hdl_pkg::word_t            hap_word,
	input  logic                      new_set,
	input  logic [hdl_pkg::LEN_W-1:0] len,
	output logic                      busy,
	output logic                      job_valid,
	output hdl_pkg::job_t             job,
	input  logic                      job_pop
);
	import hdl_pkg::*;

	logic [WIDX-1:0]     pos_q;
	logic                clr_q;
	word_t               buf_q [MAX_WORDS];
	job_t                q_q [QDEPTH];
	logic [QPW-1:0]      wp_q, rp_q;
	logic [QPW:0]        cnt_q;
	logic                acc, last, push;
	job_t                nj;

	assign busy = (32'(cnt_q) == QDEPTH);
	assign acc  = start && !busy;
	assign last = ((LEN_W'(pos_q) + LEN_W'(1)) >= len);
	assign push = acc && last;

	always_comb begin
		for (int i = 0; i < MAX_WORDS; i++) begin
			nj.key[i] = (WIDX'(i) == pos_q) ? hap_word : buf_q[i];
		end
		nj.key[0][0] = 1'b0;
		nj.clear     = (pos_q == '0) ? new_set : clr_q;
		nj.len       = len;
	end

	assign job_valid = (cnt_q != '0);
	assign job       = q_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			clr_q <= 1'b0;
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) begin
				buf_q[pos_q] <= hap_word;
				if (pos_q == '0) begin
					clr_q <= new_set;
				end
				pos_q <= last ? '0 : pos_q + WIDX'(1);
			end
			if (push) begin
				q_q[wp_q] <= nj;
				wp_q      <= wp_q + QPW'(1);
			end
			if (job_pop && job_valid) begin
				rp_q <= rp_q + QPW'(1);
			end
			cnt_q <= cnt_q + (QPW+1)'(push) - (QPW+1)'(job_pop && job_valid);
		end
	end
endmodule

[hw/rtl/hdl_back.sv]
// Back part: searches the key store for a queued key, stores new keys, emits labels.
// Depends on hdl_pkg, hdl_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "haplotype_distinct_labeler_defines.svh"
module hdl_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	input  hdl_pkg::job_t               job,
	output logic                        job_pop,
	output logic                        result_valid,
	output logic [hdl_pkg::LABEL_W-1:0] type_label,
	output logic                        is_new,
	output logic                        overflow
);
	import hdl_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_WR, S_WAIT} state_t;

	state_t            state_q;
	logic [ENT_W-1:0]  e_q;
	logic [WIDX-1:0]   w_q;
	logic [CNT_W-1:0]  count_q;
	logic              we;
	logic [RAM_AW-1:0] waddr, raddr;
	word_t             rdata, kw;
	logic              wlast, full;

	assign kw    = job.key[w_q];
	assign wlast = (LEN_W'(w_q) == job.len - LEN_W'(1));
	assign full  = (32'(count_q) >= ENTRIES);
	assign we    = (state_q == S_WR) && !full;
	assign waddr = {count_q[ENT_W-1:0], w_q};
	assign raddr = {e_q, w_q};

	hdl_ram #(.WIDTH(WORD_BITS), .DEPTH(RAM_DEPTH)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(kw), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			e_q          <= '0;
			w_q          <= '0;
			count_q      <= '0;
			job_pop      <= 1'b0;
			result_valid <= 1'b0;
			type_label   <= '0;
			is_new       <= 1'b0;
			overflow     <= 1'b0;
		end else begin
			job_pop      <= 1'b0;
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						e_q <= '0;
						w_q <= '0;
						if (job.clear) begin
							count_q <= '0;
						end
						if (job.clear || count_q == '0) begin
							state_q <= S_WR;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (rdata == kw) begin
						if (wlast) begin
							result_valid <= 1'b1;
							type_label   <= LABEL_W'(e_q) + LABEL_W'(1);
							is_new       <= 1'b0;
							overflow     <= 1'b0;
							job_pop      <= 1'b1;
							state_q      <= S_WAIT;
						end else begin
							w_q     <= w_q + WIDX'(1);
							state_q <= S_RD;
						end
					end else if (CNT_W'(e_q) + CNT_W'(1) == count_q) begin
						w_q     <= '0;
						state_q <= S_WR;
					end else begin
						e_q     <= e_q + ENT_W'(1);
						w_q     <= '0;
						state_q <= S_RD;
					end
				end
				S_WR: begin
					if (full) begin
						result_valid <= 1'b1;
						type_label   <= '0;
						is_new       <= 1'b1;
						overflow     <= 1'b1;
						job_pop      <= 1'b1;
						state_q      <= S_WAIT;
					end else if (wlast) begin
						count_q      <= count_q + CNT_W'(1);
						result_valid <= 1'b1;
						type_label   <= LABEL_W'(count_q) + LABEL_W'(1);
						is_new       <= 1'b1;
						overflow     <= 1'b0;
						job_pop      <= 1'b1;
						state_q      <= S_WAIT;
					end else begin
						w_q <= w_q + WIDX'(1);
					end
				end
				S_WAIT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`HDL_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_q) <= ENTRIES, "label count above table size")
	`HDL_ASSERT_NOW(a_ovf_form, result_valid && overflow, is_new && type_label == '0, "bad overflow beat")
	`HDL_ASSERT_NEXT(a_pop_once, job_pop, !job_pop && !result_valid, "pop repeated")
	`HDL_ASSERT_NOW(a_pop_beat, job_pop, result_valid, "pop without result beat")
endmodule

[hw/rtl/haplotype_distinct_labeler.sv]
// Top level of the distinct haplotype labeler: APB register, front and back parts.
// Depends on hdl_pkg, hdl_front, hdl_back.
//
// channel  | handshake                  | payload
// input    | start && !busy             | hap_word, new_set
// result   | result_valid (one cycle)   | type_label, is_new, overflow
// config   | psel & penable & pwrite    | paddr, pwdata (words_in_use at 0)
//
// A word that does not complete a haplotype is only buffered in the front part.
// A completed key is searched by reading and comparing each stored key word by word
// (S_RD, S_CMP); if none matches, the new key is written word by word in S_WR, and the
// back returns through S_WAIT to S_IDLE. A full table holds 256 keys.
// Reset leaves the table empty and words_in_use at 8. A two-deep key queue lets the
// front take words while the back searches; busy rises when that queue is full.
`timescale 1ns / 1ps
module haplotype_distinct_labeler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  hdl_pkg::word_t              hap_word,
	input  logic                        new_set,
	output logic                        result_valid,
	output logic [hdl_pkg::LABEL_W-1:0] type_label,
	output logic                        is_new,
	output logic                        overflow,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import hdl_pkg::*;

	localparam logic [2:0] ADDR_WORDS = 3'd0;

	logic [CFG_W-1:0] words_in_use_q;
	logic             job_valid, job_pop;
	job_t             job;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_WORDS) ? 32'(words_in_use_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_in_use_q <= CFG_W'(8);
		end else if (psel && penable && pwrite && paddr == ADDR_WORDS) begin
			words_in_use_q <= pwdata[CFG_W-1:0];
		end
	end

	hdl_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .hap_word(hap_word),
		.new_set(new_set), .len(eff_len(words_in_use_q)), .busy(busy),
		.job_valid(job_valid), .job(job), .job_pop(job_pop)
	);

	hdl_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job), .job_pop(job_pop),
		.result_valid(result_valid), .type_label(type_label), .is_new(is_new),
		.overflow(overflow)
	);
endmodule
